>>> sv/dual_aes_sbox_composite_field_top_macros.svh
// ----------------------------------------------------------------------------
// dual aes s-box assertion macros
// shared concurrent assertion forms, clocked on clk
// ----------------------------------------------------------------------------
`ifndef DUAL_AES_SBOX_COMPOSITE_FIELD_TOP_MACROS_SVH
`define DUAL_AES_SBOX_COMPOSITE_FIELD_TOP_MACROS_SVH

// checked only while out of reset
`define DAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define DAS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/dasbox_pkg.sv
// ----------------------------------------------------------------------------
// dasbox_pkg
// composite field arithmetic and basis matrices for the dual aes s-box
// ----------------------------------------------------------------------------
package dasbox_pkg;

  localparam int unsigned Lanes   = 2;
  localparam int unsigned Latency = 5;

  localparam logic [7:0] SBOX_AFFINE = 8'h63;

  // polynomial basis to normal basis
  localparam logic [7:0] TO_NORMAL [8] = '{
    8'h98, 8'hF3, 8'hF2, 8'h48, 8'h09, 8'h81, 8'hA9, 8'hFF
  };

  // normal basis to s-box output basis, affine matrix folded in
  localparam logic [7:0] TO_SBOX [8] = '{
    8'h58, 8'h2D, 8'h9E, 8'h0B, 8'hDC, 8'h04, 8'h03, 8'h24
  };

  typedef logic [7:0] byte_t;
  typedef logic [3:0] nib_t;

  // bit k of u selects row 7-k
  function automatic byte_t change_basis(input byte_t u, input logic [7:0] rows [8]);
    byte_t acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (u[k]) begin
        acc = acc ^ rows[7 - k];
      end
    end
    return acc;
  endfunction

  function automatic logic [1:0] f4_mul(input logic [1:0] u, input logic [1:0] v);
    logic s;
    s = (u[1] ^ u[0]) & (v[1] ^ v[0]);
    return {(u[1] & v[1]) ^ s, (u[0] & v[0]) ^ s};
  endfunction

  function automatic logic [1:0] f4_times_n(input logic [1:0] u);
    return {u[0], u[1] ^ u[0]};
  endfunction

  function automatic logic [1:0] f4_times_n2(input logic [1:0] u);
    return {u[1] ^ u[0], u[1]};
  endfunction

  function automatic logic [1:0] f4_square(input logic [1:0] u);
    return {u[0], u[1]};
  endfunction

  function automatic nib_t f16_mul(input nib_t u, input nib_t v);
    logic [1:0] s;
    s = f4_times_n(f4_mul(u[3:2] ^ u[1:0], v[3:2] ^ v[1:0]));
    return {f4_mul(u[3:2], v[3:2]) ^ s, f4_mul(u[1:0], v[1:0]) ^ s};
  endfunction

  function automatic nib_t f16_square_scale(input nib_t u);
    return {f4_square(u[3:2] ^ u[1:0]), f4_times_n2(f4_square(u[1:0]))};
  endfunction

  function automatic nib_t f16_inv(input nib_t u);
    logic [1:0] c;
    logic [1:0] d;
    logic [1:0] r;
    c = f4_times_n(f4_square(u[3:2] ^ u[1:0]));
    d = f4_mul(u[3:2], u[1:0]);
    r = f4_square(c ^ d);
    return {f4_mul(r, u[1:0]), f4_mul(r, u[3:2])};
  endfunction

endpackage

>>> sv/dual_aes_sbox_composite_field_top.sv
// ----------------------------------------------------------------------------
// dual aes s-box, composite field
// two independent copies of the forward s-box in a five stage pipeline
// ----------------------------------------------------------------------------
//  channel  ports                                        handshake
//  input    in_byte                                      start, busy
//  result   out_sbox_copy_two, out_sbox_copy_one         out_strobe
//
//  one byte per cycle; a result passes through the registered stages below and
//  is on the ports while the output map register holds it
//  stages: basis change, subfield split, gf(2^4) inverse, recombine, output map
//  the result strobe lasts one cycle and the receiver cannot stall it
//  synchronous reset clears all valid bits and holds busy high
//  busy drops on the edge that samples reset released and stays low; the pipeline never stalls
// ----------------------------------------------------------------------------
`include "dual_aes_sbox_composite_field_top_macros.svh"

module dual_aes_sbox_composite_field_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_byte,
  output logic       out_strobe,
  output logic [7:0] out_sbox_copy_two,
  output logic [7:0] out_sbox_copy_one
);

  localparam int unsigned N = dasbox_pkg::Lanes;

  logic busy_r;
  logic [dasbox_pkg::Latency-1:0] vld_r;
  logic [dasbox_pkg::Latency-1:0] vld_nxt;

  dasbox_pkg::byte_t t1_r   [N];
  dasbox_pkg::byte_t t1_nxt [N];
  dasbox_pkg::nib_t  hi2_r  [N];
  dasbox_pkg::nib_t  lo2_r  [N];
  dasbox_pkg::nib_t  cd2_r  [N];
  dasbox_pkg::nib_t  cd2_nxt[N];
  dasbox_pkg::nib_t  hi3_r  [N];
  dasbox_pkg::nib_t  lo3_r  [N];
  dasbox_pkg::nib_t  r3_r   [N];
  dasbox_pkg::nib_t  r3_nxt [N];
  dasbox_pkg::byte_t inv4_r [N];
  dasbox_pkg::byte_t inv4_nxt[N];
  dasbox_pkg::byte_t sb5_r  [N];
  dasbox_pkg::byte_t sb5_nxt[N];

  assign vld_nxt = {vld_r[dasbox_pkg::Latency-2:0], start & ~busy_r};

  always_comb begin
    for (int i = 0; i < N; i++) begin
      t1_nxt[i]   = dasbox_pkg::change_basis(in_byte, dasbox_pkg::TO_NORMAL);
      cd2_nxt[i]  = dasbox_pkg::f16_square_scale(t1_r[i][7:4] ^ t1_r[i][3:0])
                    ^ dasbox_pkg::f16_mul(t1_r[i][7:4], t1_r[i][3:0]);
      r3_nxt[i]   = dasbox_pkg::f16_inv(cd2_r[i]);
      inv4_nxt[i] = {dasbox_pkg::f16_mul(r3_r[i], lo3_r[i]),
                     dasbox_pkg::f16_mul(r3_r[i], hi3_r[i])};
      sb5_nxt[i]  = dasbox_pkg::change_basis(inv4_r[i], dasbox_pkg::TO_SBOX)
                    ^ dasbox_pkg::SBOX_AFFINE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      t1_r[i]   <= t1_nxt[i];
      hi2_r[i]  <= t1_r[i][7:4];
      lo2_r[i]  <= t1_r[i][3:0];
      cd2_r[i]  <= cd2_nxt[i];
      hi3_r[i]  <= hi2_r[i];
      lo3_r[i]  <= lo2_r[i];
      r3_r[i]   <= r3_nxt[i];
      inv4_r[i] <= inv4_nxt[i];
      sb5_r[i]  <= sb5_nxt[i];
    end
  end

  assign busy              = busy_r;
  assign out_strobe        = vld_r[dasbox_pkg::Latency-1];
  assign out_sbox_copy_one = sb5_r[0];
  assign out_sbox_copy_two = sb5_r[1];

  `DAS_ASSERT(a_copies_agree, out_strobe |-> (out_sbox_copy_one == out_sbox_copy_two),
    "redundant s-box copies disagree")
  `DAS_ASSERT(a_beat_emerges, (start && !busy) |-> ##5 out_strobe,
    "accepted beat did not produce a result")
  `DAS_ASSERT(a_no_phantom, out_strobe |-> $past(start && !busy, 5),
    "result strobe without an accepted beat")
  `DAS_ASSERT_ALWAYS(a_busy_released, (rst_n && $past(rst_n)) |-> !busy,
    "busy high outside reset")

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: dual aes s-box, composite field
// pushes single bytes through the start/busy port in random bursts, predicts
// both s-box copies with an independent composite field model and compares
// each strobed result, field by field, against the oldest pending beat
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned PIPE_DEPTH = 5;
  localparam int unsigned RAND_BEATS = 830;
  localparam logic [7:0]  AFFINE_XOR = 8'h63;

  // polynomial to normal basis, then normal basis to s-box output basis
  localparam logic [7:0] NB_ROWS [8] = '{
    8'h98, 8'hF3, 8'hF2, 8'h48, 8'h09, 8'h81, 8'hA9, 8'hFF
  };
  localparam logic [7:0] OUT_ROWS [8] = '{
    8'h58, 8'h2D, 8'h9E, 8'h0B, 8'hDC, 8'h04, 8'h03, 8'h24
  };

  typedef struct packed {
    logic [7:0] copy_two;
    logic [7:0] copy_one;
  } sbox_pair_t;

  class sbox_scoreboard;
    sbox_pair_t  pending_q [$];
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned n_noted;

    function new();
      n_errors  = 0;
      n_checked = 0;
      n_noted   = 0;
    endfunction

    static function logic [1:0] mul_gf4(logic [1:0] u, logic [1:0] v);
      logic s;
      s = (u[1] ^ u[0]) & (v[1] ^ v[0]);
      return {(u[1] & v[1]) ^ s, (u[0] & v[0]) ^ s};
    endfunction

    static function logic [1:0] scl_n_gf4(logic [1:0] u);
      return {u[0], u[1] ^ u[0]};
    endfunction

    static function logic [1:0] scl_n2_gf4(logic [1:0] u);
      return {u[1] ^ u[0], u[1]};
    endfunction

    static function logic [1:0] sq_gf4(logic [1:0] u);
      return {u[0], u[1]};
    endfunction

    static function logic [3:0] mul_gf16(logic [3:0] u, logic [3:0] v);
      logic [1:0] s;
      s = scl_n_gf4(mul_gf4(u[3:2] ^ u[1:0], v[3:2] ^ v[1:0]));
      return {mul_gf4(u[3:2], v[3:2]) ^ s, mul_gf4(u[1:0], v[1:0]) ^ s};
    endfunction

    static function logic [3:0] sqscl_gf16(logic [3:0] u);
      return {sq_gf4(u[3:2] ^ u[1:0]), scl_n2_gf4(sq_gf4(u[1:0]))};
    endfunction

    static function logic [3:0] inv_gf16(logic [3:0] u);
      logic [1:0] c;
      logic [1:0] d;
      logic [1:0] r;
      c = scl_n_gf4(sq_gf4(u[3:2] ^ u[1:0]));
      d = mul_gf4(u[3:2], u[1:0]);
      r = sq_gf4(c ^ d);
      return {mul_gf4(r, u[1:0]), mul_gf4(r, u[3:2])};
    endfunction

    // zero maps to zero
    static function logic [7:0] inv_gf256(logic [7:0] u);
      logic [3:0] c;
      logic [3:0] d;
      logic [3:0] r;
      c = sqscl_gf16(u[7:4] ^ u[3:0]);
      d = mul_gf16(u[7:4], u[3:0]);
      r = inv_gf16(c ^ d);
      return {mul_gf16(r, u[3:0]), mul_gf16(r, u[7:4])};
    endfunction

    // bit i of u picks row 7-i
    static function logic [7:0] map_basis(logic [7:0] u, logic [7:0] rows [8]);
      logic [7:0] acc;
      acc = '0;
      for (int i = 0; i < 8; i++) begin
        if (u[i]) begin
          acc = acc ^ rows[7 - i];
        end
      end
      return acc;
    endfunction

    static function logic [7:0] subst_byte(logic [7:0] b);
      return map_basis(inv_gf256(map_basis(b, NB_ROWS)), OUT_ROWS) ^ AFFINE_XOR;
    endfunction

    function void note_beat(logic [7:0] b);
      sbox_pair_t exp_pair;
      exp_pair.copy_two = subst_byte(b);
      exp_pair.copy_one = subst_byte(b);
      pending_q.push_back(exp_pair);
      n_noted++;
    endfunction

    function void check_beat(logic [7:0] two, logic [7:0] one);
      sbox_pair_t exp_pair;
      if (pending_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing pending: copy_two=%02h copy_one=%02h",
                 $time, two, one);
        return;
      end
      exp_pair = pending_q.pop_front();
      n_checked++;
      if (two !== exp_pair.copy_two) begin
        n_errors++;
        $display("%0t: copy_two mismatch: expected %02h actual %02h",
                 $time, exp_pair.copy_two, two);
      end
      if (one !== exp_pair.copy_one) begin
        n_errors++;
        $display("%0t: copy_one mismatch: expected %02h actual %02h",
                 $time, exp_pair.copy_one, one);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [7:0] in_byte;
  logic       out_strobe;
  logic [7:0] out_sbox_copy_two;
  logic [7:0] out_sbox_copy_one;

  sbox_scoreboard sb = new();
  int unsigned    burst_left = 0;

  dual_aes_sbox_composite_field_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_byte           (in_byte),
    .out_strobe        (out_strobe),
    .out_sbox_copy_two (out_sbox_copy_two),
    .out_sbox_copy_one (out_sbox_copy_one)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // monitor: note accepted beats, then check strobed results
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (start === 1'b1 && busy === 1'b0) begin
        sb.note_beat(in_byte);
      end
      if (out_strobe === 1'b1) begin
        sb.check_beat(out_sbox_copy_two, out_sbox_copy_one);
      end
    end
  end

  task automatic send_beat(input logic [7:0] b);
    start   <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // bursts of random length, gaps of random length, some gapless stretches
  task automatic send_paced(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        idle_cycles(gap);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 20);
    end
    send_beat(b);
    burst_left--;
  endtask

  initial begin
    logic [7:0] directed [$];
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_byte <= 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero, all ones, each single bit, checkerboards, a few known points
    directed = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
                 8'h80, 8'hFE, 8'h7F, 8'hAA, 8'h55, 8'h63, 8'h53, 8'hCA, 8'h0F,
                 8'hF0};
    foreach (directed[i]) begin
      send_beat(directed[i]);
    end
    idle_cycles(3);

    // full sweep of the input space, then random bytes
    for (int v = 0; v < 256; v++) begin
      send_paced(v[7:0]);
    end
    for (int n = 0; n < RAND_BEATS; n++) begin
      send_paced(8'($urandom_range(0, 255)));
    end
    start <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    $display("covered %0d beats: directed corner bytes, a full 0..255 sweep and random",
             sb.n_noted);
    $display("checked %0d result pairs under random bursts and gaps", sb.n_checked);
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS dual_aes_sbox_composite_field_top");
    end else begin
      $display("FAIL dual_aes_sbox_composite_field_top");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout, %0d beats still pending", sb.pending_q.size());
    $display("FAIL dual_aes_sbox_composite_field_top");
    $finish;
  end

endmodule
